>>> rtl/core/sqf_pkg.sv
// Shared types, widths and constants of the stereo quadrature flanger.
package sqf_pkg;

    // Default structural parameters
    localparam int LINE_DEPTH_DEF  = 8192;
    localparam int MAX_TAP_DEF     = 4097;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths
    localparam int GAIN_W    = 16;  // Q1.15
    localparam int SPAN_W    = 24;  // unsigned Q16.8
    localparam int OSC_W     = 31;  // Q1.30 step coefficients
    localparam int LFO_W     = 32;  // Q2.30 oscillator state
    localparam int LFO_SHIFT = 30;
    localparam int OFF_W     = 33;  // lfo plus three, always positive
    localparam int DPROD_W   = SPAN_W + OFF_W;
    localparam int D_SHIFT   = 22;
    localparam int FRAC_W    = 16;
    localparam int IP_W      = DPROD_W - D_SHIFT - FRAC_W;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SPAN    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_SIN       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_COS       = 8'd3;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_RST    = 16'sd16384;
    localparam logic [SPAN_W-1:0]        SPAN_RST    = 24'd56448;
    localparam logic signed [OSC_W-1:0]  OSC_SIN_RST = 31'sd76494;
    localparam logic signed [OSC_W-1:0]  OSC_COS_RST = 31'sd1073741821;

    // Sequencer steps
    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_MUL   = 11'b000_0000_0100,
        S_OSC   = 11'b000_0000_1000,
        S_DMUL  = 11'b000_0001_0000,
        S_TAP   = 11'b000_0010_0000,
        S_MOD   = 11'b000_0100_0000,
        S_RDA   = 11'b000_1000_0000,
        S_RDB   = 11'b001_0000_0000,
        S_MIX   = 11'b010_0000_0000,
        S_SUM   = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        t_state state;
        logic   advance;   // low only while the last step is held by a blocked output
    } t_ctl;

endpackage

>>> rtl/core/sqf_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module sqf_ram
    import sqf_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF,
    parameter int DEPTH = LINE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sqf_osc.sv
// Quadrature rotation oscillator giving the sine and cosine LFO values.
module sqf_osc
    import sqf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic signed [OSC_W-1:0] i_osc_sin,
    input  logic signed [OSC_W-1:0] i_osc_cos,
    output logic signed [LFO_W-1:0] o_lfo_sin,
    output logic signed [LFO_W-1:0] o_lfo_cos
);

    localparam int P_W = OSC_W + LFO_W;
    localparam int S_W = 64;
    localparam logic signed [S_W-1:0] HALF = S_W'(64'sd1 <<< (LFO_SHIFT - 1));
    localparam logic [LFO_W-1:0] KICK = LFO_W'(64'd1 << LFO_SHIFT);

    logic signed [P_W-1:0]   r_p_sc, r_p_cs, r_p_cc, r_p_ss;
    logic signed [LFO_W-1:0] r_sin, r_cos;
    logic                    r_started;
    logic signed [S_W-1:0]   sum_sin, sum_cos;
    logic [LFO_W-1:0]        n_sin, n_cos;

    always_comb begin
        sum_sin = S_W'(r_p_sc) + S_W'(r_p_cs) + HALF;
        sum_cos = S_W'(r_p_cc) - S_W'(r_p_ss) + HALF;
        n_sin   = sum_sin[LFO_SHIFT +: LFO_W];
        n_cos   = sum_cos[LFO_SHIFT +: LFO_W] + (r_started ? '0 : KICK);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.state == S_MUL) begin
            r_p_sc <= i_osc_sin * r_cos;
            r_p_cs <= i_osc_cos * r_sin;
            r_p_cc <= i_osc_cos * r_cos;
            r_p_ss <= i_osc_sin * r_sin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin     <= '0;
            r_cos     <= '0;
            r_started <= 1'b0;
        end else if (i_ctl.state == S_OSC) begin
            r_sin     <= $signed(n_sin);
            r_cos     <= $signed(n_cos);
            r_started <= 1'b1;
        end
    end

    assign o_lfo_sin = r_sin;
    assign o_lfo_cos = r_cos;

endmodule

>>> rtl/core/sqf_lane.sv
// One channel: feedback write, modulated delay taps, interpolation and mix.
module sqf_lane
    import sqf_pkg::*;
#(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int MAX_TAP     = MAX_TAP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl                          i_ctl,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_wi,
    input  logic signed [SAMPLE_BITS-1:0] i_dry,
    input  logic signed [GAIN_W-1:0]      i_gain,
    input  logic [SPAN_W-1:0]             i_span,
    input  logic signed [LFO_W-1:0]       i_lfo,
    output logic signed [SAMPLE_BITS-1:0] o_res
);

    localparam int ADDR_W    = $clog2(LINE_DEPTH);
    localparam int TAP_W     = $clog2(MAX_TAP + 1);
    localparam int MW        = ((TAP_W > ADDR_W) ? TAP_W : ADDR_W) + 1;
    localparam int MOD_STEPS = (TAP_W >= ADDR_W) ? (TAP_W - ADDR_W + 1) : 1;
    localparam logic [MW-1:0] DM = MW'(LINE_DEPTH);
    localparam int FB_W  = SAMPLE_BITS + GAIN_W;
    localparam int MIX_W = SAMPLE_BITS + FRAC_W + 2;
    localparam int SUM_W = MIX_W + 1;

    // Clamp a tap to the legal range
    function automatic logic [TAP_W-1:0] clamp_tap(input logic [IP_W:0] t);
        if (t > (IP_W + 1)'(MAX_TAP)) begin
            return TAP_W'(MAX_TAP);
        end
        return t[TAP_W-1:0];
    endfunction

    // Reduce the tap modulo the line depth, then step back from the write index
    function automatic logic [ADDR_W-1:0] tap_addr(input logic [ADDR_W-1:0] wi,
                                                   input logic [TAP_W-1:0]  t);
        logic [MW-1:0]   r;
        logic [ADDR_W:0] diff;
        r = MW'(t);
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= (DM << k)) begin
                r = r - (DM << k);
            end
        end
        diff = {1'b0, wi} - {1'b0, r[ADDR_W-1:0]};
        if (diff[ADDR_W]) begin
            diff = diff + (ADDR_W + 1)'(LINE_DEPTH);
        end
        return diff[ADDR_W-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_wet;
    logic signed [FB_W-1:0]        r_fb_prod;
    logic [DPROD_W-1:0]            r_dprod;
    logic [TAP_W-1:0]              r_t0, r_t1;
    logic [FRAC_W-1:0]             r_f;
    logic [ADDR_W-1:0]             r_addr0, r_addr1;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [MIX_W-1:0]       r_pa, r_pb;

    logic                          we;
    logic [SAMPLE_BITS-1:0]        wdata, fb_val;
    logic signed [FB_W-1:0]        fb_rnd;
    logic [ADDR_W-1:0]             raddr;
    logic [SAMPLE_BITS-1:0]        rdata;
    logic [OFF_W+1:0]              off_ext;
    logic [OFF_W-1:0]              off;
    logic [IP_W:0]                 ip0, ip1;
    logic [FRAC_W:0]               w0;
    logic signed [SUM_W-1:0]       mix_sum;
    logic signed [SAMPLE_BITS-1:0] n_wet;
    logic [SAMPLE_BITS:0]          out_sum;

    always_comb begin
        fb_rnd  = r_fb_prod + FB_W'(16384);
        fb_val  = fb_rnd[15 +: SAMPLE_BITS] - i_dry;
        we      = (i_ctl.state == S_CLEAR) || (i_ctl.state == S_OSC);
        wdata   = (i_ctl.state == S_CLEAR) ? '0 : fb_val;
        raddr   = (i_ctl.state == S_RDB) ? r_addr1 : r_addr0;
        // lfo plus three in Q2.30, always positive
        off_ext = {{3{i_lfo[LFO_W-1]}}, i_lfo} + ((OFF_W + 2)'(3) << LFO_SHIFT);
        off     = off_ext[OFF_W-1:0];
        ip0     = {1'b0, r_dprod[DPROD_W-1 -: IP_W]};
        ip1     = ip0 + (IP_W + 1)'(1);
        w0      = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, r_f};
        mix_sum = SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(32768);
        n_wet   = $signed(mix_sum[FRAC_W +: SAMPLE_BITS]);
        out_sum = {n_wet[SAMPLE_BITS-1], n_wet} + {i_dry[SAMPLE_BITS-1], i_dry};
        o_res   = $signed(out_sum[SAMPLE_BITS:1]);
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.state)
            S_MUL:   r_fb_prod <= i_gain * r_wet;
            S_DMUL:  r_dprod <= i_span * off;
            S_TAP: begin
                r_f  <= r_dprod[D_SHIFT +: FRAC_W];
                r_t0 <= clamp_tap(ip0);
                r_t1 <= clamp_tap(ip1);
            end
            S_MOD: begin
                r_addr0 <= tap_addr(i_wi, r_t0);
                r_addr1 <= tap_addr(i_wi, r_t1);
            end
            S_RDB:   r_a <= $signed(rdata);
            S_MIX: begin
                r_pa <= r_a * $signed({1'b0, w0});
                r_pb <= $signed(rdata) * $signed({2'b00, r_f});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet <= '0;
        end else if (i_ctl.state == S_SUM && i_ctl.advance) begin
            r_wet <= n_wet;
        end
    end

    sqf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_wi),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

>>> rtl/core/stereo_quadrature_flanger.sv
// Top level of the stereo quadrature flanger: sequencer, registers, output stage.
//
//  channel  direction  handshake                   payload
//  -------  ---------  --------------------------  -----------------------------
//  in       sink       i_in_valid / o_in_stall     i_in_left, i_in_right
//  out      source     o_out_valid / i_out_stall   o_out_left, o_out_right
//  cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One stereo item takes the accept step plus nine sequencer steps.
//  The step count is set by the delay-line RAM with its single read port (two taps
//  read one after the other) and by the chain of registered multiply steps.
//  After reset both delay lines are cleared, one entry per cycle, across all
//  LINE_DEPTH entries (8192 by default); o_in_stall stays high meanwhile.
//  One output register holds a finished item; the next input is taken while it
//  waits, and the last step holds until that register is free.
module stereo_quadrature_flanger
    import sqf_pkg::*;
#(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int MAX_TAP     = MAX_TAP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_left,
    input  logic signed [SAMPLE_BITS-1:0] i_in_right,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);

    t_state                        r_state, n_state;
    logic [ADDR_W-1:0]             r_wi;
    logic signed [SAMPLE_BITS-1:0] r_dry_l, r_dry_r;
    logic signed [GAIN_W-1:0]      r_gain;
    logic [SPAN_W-1:0]             r_span;
    logic signed [OSC_W-1:0]       r_osc_sin, r_osc_cos;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;

    t_ctl                          ctl;
    logic                          advance;
    logic                          in_take;
    logic                          finish;
    logic signed [LFO_W-1:0]       lfo_sin, lfo_cos;
    logic signed [SAMPLE_BITS-1:0] res_l, res_r;

    // Hold the last step while the previous result still waits downstream
    assign advance     = !(r_state == S_SUM && r_out_valid && i_out_stall);
    assign finish      = (r_state == S_SUM) && advance;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign ctl         = '{state: r_state, advance: advance};

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_wi == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL:   n_state = S_OSC;
            S_OSC:   n_state = S_DMUL;
            S_DMUL:  n_state = S_TAP;
            S_TAP:   n_state = S_MOD;
            S_MOD:   n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_MIX;
            S_MIX:   n_state = S_SUM;
            S_SUM:   if (advance) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wi    <= '0;
        end else begin
            r_state <= n_state;
            // Step through the lines during the clear pass, once per item after
            if (r_state == S_CLEAR || finish) begin
                r_wi <= (r_wi == LAST_ADDR) ? '0 : r_wi + ADDR_W'(1);
            end
        end
    end

    // Capture the dry pair with the item
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dry_l <= i_in_left;
            r_dry_r <= i_in_right;
        end
    end

    // Configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RST;
            r_span    <= SPAN_RST;
            r_osc_sin <= OSC_SIN_RST;
            r_osc_cos <= OSC_COS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FEEDBACK_GAIN: r_gain    <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_DELAY_SPAN:    r_span    <= i_cfg_data[SPAN_W-1:0];
                CFG_OSC_SIN:       r_osc_sin <= $signed(i_cfg_data[OSC_W-1:0]);
                CFG_OSC_COS:       r_osc_cos <= $signed(i_cfg_data[OSC_W-1:0]);
                default: ;
            endcase
        end
    end

    // Output register: load on the last step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_l <= res_l;
            r_out_r <= res_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

    sqf_osc u_osc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_osc_sin (r_osc_sin),
        .i_osc_cos (r_osc_cos),
        .o_lfo_sin (lfo_sin),
        .o_lfo_cos (lfo_cos)
    );

    // Left follows the sine, right the cosine
    sqf_lane #(
        .LINE_DEPTH  (LINE_DEPTH),
        .MAX_TAP     (MAX_TAP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_wi    (r_wi),
        .i_dry   (r_dry_l),
        .i_gain  (r_gain),
        .i_span  (r_span),
        .i_lfo   (lfo_sin),
        .o_res   (res_l)
    );

    sqf_lane #(
        .LINE_DEPTH  (LINE_DEPTH),
        .MAX_TAP     (MAX_TAP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_wi    (r_wi),
        .i_dry   (r_dry_r),
        .i_gain  (r_gain),
        .i_span  (r_span),
        .i_lfo   (lfo_cos),
        .o_res   (res_r)
    );

    // A finished item always lands in the output register
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished item not presented");

    // The write index moves only during the clear pass or at the end of an item
    a_wi_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR && r_state != S_SUM) |=> $stable(r_wi))
        else $error("write index moved mid item");

    // The clear pass leaves the write index at the start of the line
    a_clear_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_CLEAR) |-> (r_wi == '0))
        else $error("clear pass ended off the line start");

    // A blocked last step stays put
    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_out_valid && i_out_stall) |=> (r_state == S_SUM))
        else $error("last step left while output blocked");

endmodule

>>> bench/sqf_flange_checker.sv
// Watches the flanger's channels, predicts each flanged pair and compares it with the output.
module sqf_flange_checker
    import sqf_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [SAMPLE_BITS_DEF-1:0] i_in_left,
    input  logic signed [SAMPLE_BITS_DEF-1:0] i_in_right,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [SAMPLE_BITS_DEF-1:0] i_out_left,
    input  logic signed [SAMPLE_BITS_DEF-1:0] i_out_right,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_result_count
);

    localparam int SB    = SAMPLE_BITS_DEF;
    localparam int DEPTH = LINE_DEPTH_DEF;
    localparam int PTR_W = $clog2(LINE_DEPTH_DEF);

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
    } t_flanged_pair;

    // Shadow of the block: two delay lines, oscillator, last wet values, registers.
    logic signed [SB-1:0]     delay_line [2][DEPTH];
    logic signed [SB-1:0]     wet_last   [2];
    logic [PTR_W-1:0]         wr_ptr;
    logic signed [LFO_W-1:0]  lfo_s;
    logic signed [LFO_W-1:0]  lfo_c;
    logic                     lfo_running;
    logic signed [GAIN_W-1:0] gain_q15;
    logic [SPAN_W-1:0]        span_q8;
    logic signed [OSC_W-1:0]  step_sin;
    logic signed [OSC_W-1:0]  step_cos;

    t_flanged_pair expected_pairs [$];

    function automatic longint clamp_tap(input longint t);
        if (t < 0) return 0;
        if (t > MAX_TAP_DEF) return MAX_TAP_DEF;
        return t;
    endfunction

    // Write the feedback entry, read the two taps, blend them; return the mixed output.
    function automatic logic [SB-1:0] flange_channel(input int ch, input longint dry,
                                                     input longint lfo);
        longint fbv, tmp, prod, d, ip, f, t0, t1, a, b, y, mix;
        int     ra, rb;
        fbv = (longint'(gain_q15) * longint'(wet_last[ch]) + 16384) >>> 15;
        tmp = fbv - dry;
        delay_line[ch][wr_ptr] = tmp[SB-1:0];
        prod = longint'(span_q8) * (lfo + (longint'(3) << LFO_SHIFT));
        d    = prod >>> D_SHIFT;
        ip   = d >>> FRAC_W;
        f    = longint'(d[FRAC_W-1:0]);
        t0   = clamp_tap(ip) % DEPTH;
        t1   = clamp_tap(ip + 1) % DEPTH;
        ra   = (int'(wr_ptr) + DEPTH - int'(t0)) % DEPTH;
        rb   = (int'(wr_ptr) + DEPTH - int'(t1)) % DEPTH;
        a    = delay_line[ch][ra];
        b    = delay_line[ch][rb];
        y    = (a * (65536 - f) + b * f + 32768) >>> 16;
        wet_last[ch] = y[SB-1:0];
        mix  = (longint'(wet_last[ch]) + dry) >>> 1;
        return mix[SB-1:0];
    endfunction

    function automatic t_flanged_pair flange_pair(input longint dl, input longint dr);
        longint        s, c, ns, nc;
        t_flanged_pair p;
        s  = lfo_s;
        c  = lfo_c;
        ns = (longint'(step_sin) * c + longint'(step_cos) * s + (longint'(1) << 29)) >>> 30;
        nc = (longint'(step_cos) * c - longint'(step_sin) * s + (longint'(1) << 29)) >>> 30;
        // the unit impulse kicks the cosine on the first pair only
        if (!lfo_running) nc += longint'(1) << 30;
        lfo_running = 1'b1;
        lfo_s = ns[LFO_W-1:0];
        lfo_c = nc[LFO_W-1:0];
        p.left  = flange_channel(0, dl, longint'(lfo_s));
        p.right = flange_channel(1, dr, longint'(lfo_c));
        wr_ptr  = wr_ptr + 1'b1;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_flanged_pair want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                delay_line[0][i] = '0;
                delay_line[1][i] = '0;
            end
            wet_last[0] = '0;
            wet_last[1] = '0;
            wr_ptr      = '0;
            lfo_s       = '0;
            lfo_c       = '0;
            lfo_running = 1'b0;
            gain_q15    = GAIN_RST;
            span_q8     = SPAN_RST;
            step_sin    = OSC_SIN_RST;
            step_cos    = OSC_COS_RST;
            expected_pairs.delete();
            o_fail_count   = 0;
            o_result_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FEEDBACK_GAIN: gain_q15 = i_cfg_data[GAIN_W-1:0];
                    CFG_DELAY_SPAN:    span_q8  = i_cfg_data[SPAN_W-1:0];
                    CFG_OSC_SIN:       step_sin = i_cfg_data[OSC_W-1:0];
                    CFG_OSC_COS:       step_cos = i_cfg_data[OSC_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (expected_pairs.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output pair L=%h R=%h", i_out_left, i_out_right);
                    o_fail_count++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (want.left !== i_out_left || want.right !== i_out_right) begin
                        if (o_fail_count < 10)
                            $display("pair %0d mismatch: expected L=%h R=%h, got L=%h R=%h",
                                     o_result_count, want.left, want.right,
                                     i_out_left, i_out_right);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_pairs.push_back(flange_pair(longint'(i_in_left),
                                                     longint'(i_in_right)));
        end
        o_pending = expected_pairs.size();
    end

endmodule

>>> bench/tb_stereo_quadrature_flanger.sv
// Stimulus and verdict for the stereo quadrature flanger, with the checker beside it.
module tb_stereo_quadrature_flanger;
    import sqf_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE       = 14;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 180;
    localparam int TOTAL_ITEMS  = 1400;

    localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    localparam logic [CFG_DATA_W-1:0] GAIN_MAX_WORD = 32'h0000_7FFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_MIN_WORD = 32'hFFFF_8000;
    localparam logic [CFG_DATA_W-1:0] OSC_MAX_WORD  = 32'h3FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] OSC_MIN_WORD  = 32'h4000_0000;

    // Receiver behaviors; each one holds for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_FLOW,      // never stall
        RX_COIN,      // stall half the time
        RX_SPARSE,    // stall now and then
        RX_BURSTY     // long stall runs with short openings
    } t_rx_mode;

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic signed [SB-1:0]          i_in_left    = '0;
    logic signed [SB-1:0]          i_in_right   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic signed [SB-1:0]          o_out_left;
    logic signed [SB-1:0]          o_out_right;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data   = '0;

    int fail_count;
    int pending_pairs;
    int result_count;

    // Handshakes seen at the last rising edge; the driving tasks read these at the
    // falling edge, so they never race the block's own updates.
    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;

    int       items_sent = 0;
    int       reg_writes = 0;
    int       cycles     = 0;
    bit       use_gaps   = 1'b1;
    int       burst_left = 0;
    t_rx_mode rx_mode    = RX_FLOW;
    int       rx_left    = 0;
    int       rx_run     = 0;
    bit       rx_hold    = 1'b0;

    stereo_quadrature_flanger u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_left   (i_in_left),
        .i_in_right  (i_in_right),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_left  (o_out_left),
        .o_out_right (o_out_right),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sqf_flange_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_left      (i_in_left),
        .i_in_right     (i_in_right),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_left     (o_out_left),
        .i_out_right    (o_out_right),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_pairs),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire  <= i_in_valid && !o_in_stall;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pairs still owed", cycles, pending_pairs);
            $display("[stereo_quadrature_flanger] ERROR");
            $finish;
        end
    end

    // Receiver: pick a stall behavior, hold it for a while, then pick another.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_FLOW:   i_out_stall <= 1'b0;
            RX_COIN:   i_out_stall <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_stall <= ($urandom_range(0, 7) == 0);
            default: begin
                if (rx_run == 0) begin
                    rx_hold = !rx_hold;
                    rx_run  = rx_hold ? $urandom_range(1, 16) : $urandom_range(1, 6);
                end
                rx_run--;
                i_out_stall <= rx_hold;
            end
        endcase
    end

    // Offer one pair and hold it until accepted, then pace the sender: keep valid
    // high inside a burst, drop it for a random gap when the burst runs out.
    task automatic put_pair(input logic [SB-1:0] l, input logic [SB-1:0] r);
        int gap;
        i_in_left  = l;
        i_in_right = r;
        i_in_valid = 1'b1;
        do @(negedge i_clk); while (!in_fire);
        items_sent++;
        if (use_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 20);
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(0, 30);
            end
        end
    endtask

    // Stop sending and wait until every predicted pair has come out, then let
    // the block settle.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_pairs != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid = 1'b0;
        reg_writes++;
    endtask

    function automatic logic [SB-1:0] pick_sample();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return {SB{1'b1}};
            4, 5: begin
                w = $urandom_range(0, 512);
                return SB'(w - 256);
            end
            default: return w[SB-1:0];
        endcase
    endfunction

    // Draw a register set: mostly musical settings, now and then extremes or
    // raw words, with junk in the unused upper bits.
    task automatic pick_config();
        logic [CFG_DATA_W-1:0] g, s, os, oc;
        g = $urandom;
        case ($urandom_range(0, 5))
            0: g = GAIN_MAX_WORD;
            1: g = GAIN_MIN_WORD;
            2: g[15:0] = 16'($urandom_range(0, 32767));
            default: ;
        endcase
        s = $urandom;
        case ($urandom_range(0, 7))
            0: s[SPAN_W-1:0] = '0;
            1: s[SPAN_W-1:0] = '1;
            2, 3: s[SPAN_W-1:0] = SPAN_W'($urandom_range(0, 262143));
            4, 5: s[SPAN_W-1:0] = SPAN_W'($urandom_range(0, 4000));
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                os = $urandom_range(0, 3_000_000);
                if ($urandom_range(0, 1)) os = -os;
                oc = OSC_MIN_WORD - $urandom_range(1, 3000);
            end
            3: begin
                os = $urandom_range(0, 1) ? OSC_MAX_WORD : OSC_MIN_WORD;
                oc = $urandom_range(0, 1) ? OSC_MAX_WORD : OSC_MIN_WORD;
            end
            default: begin
                os = $urandom;
                oc = $urandom;
            end
        endcase
        // an index past the last register must be ignored
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
        write_reg(CFG_FEEDBACK_GAIN, g);
        write_reg(CFG_DELAY_SPAN, s);
        write_reg(CFG_OSC_SIN, os);
        write_reg(CFG_OSC_COS, oc);
    endtask

    initial begin
        int hold_at;
        // Reset once; the block then clears both lines and stalls the input meanwhile.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings first, starting with the oscillator kick.
        put_pair('0, '0);
        put_pair(SAMPLE_MAX, SAMPLE_MIN);
        put_pair(SAMPLE_MIN, SAMPLE_MAX);
        put_pair(SB'(1), {SB{1'b1}});
        put_pair({SB{1'b1}}, SB'(1));
        put_pair(pick_sample(), pick_sample());
        drain();

        // Zero span: the first tap lands on the entry written this very step, the second one entry back.
        write_reg(CFG_FEEDBACK_GAIN, GAIN_MAX_WORD);
        write_reg(CFG_DELAY_SPAN, '0);
        put_pair(SAMPLE_MAX, SAMPLE_MAX);
        put_pair(SAMPLE_MIN, SAMPLE_MIN);
        put_pair(SAMPLE_MAX, SAMPLE_MIN);
        put_pair(SB'(12345), SB'(-54321));
        drain();

        // Largest span: taps pinned at the clamp; extreme gain and steps.
        write_reg(CFG_FEEDBACK_GAIN, GAIN_MIN_WORD);
        write_reg(CFG_DELAY_SPAN, '1);
        write_reg(CFG_OSC_SIN, OSC_MIN_WORD);
        write_reg(CFG_OSC_COS, OSC_MAX_WORD);
        put_pair(SAMPLE_MAX, SAMPLE_MAX);
        put_pair(SAMPLE_MIN, SAMPLE_MIN);
        put_pair(SAMPLE_MIN, SAMPLE_MAX);
        put_pair('0, '0);
        drain();

        // Spare indexes ignored; junk above each register's width dropped.
        write_reg(CFG_IDX_W'(4), '1);
        write_reg('1, '1);
        write_reg(CFG_FEEDBACK_GAIN, 32'hABCD_0000);
        write_reg(CFG_DELAY_SPAN, 32'hFF00_0100);
        write_reg(CFG_OSC_SIN, 32'hBFFF_FFFF);
        write_reg(CFG_OSC_COS, 32'h4000_0000);
        put_pair(SAMPLE_MAX, SAMPLE_MIN);
        put_pair(pick_sample(), pick_sample());
        put_pair(SAMPLE_MIN, SAMPLE_MAX);
        put_pair(SB'(-1), SB'(1));
        drain();

        // Smallest negative gain, reset span and steps restored.
        write_reg(CFG_FEEDBACK_GAIN, '1);
        write_reg(CFG_DELAY_SPAN, CFG_DATA_W'(SPAN_RST));
        write_reg(CFG_OSC_SIN, CFG_DATA_W'(OSC_SIN_RST));
        write_reg(CFG_OSC_COS, CFG_DATA_W'(OSC_COS_RST));
        put_pair(SAMPLE_MAX, SAMPLE_MAX);
        put_pair(SAMPLE_MIN, SAMPLE_MIN);
        put_pair(pick_sample(), pick_sample());
        put_pair(pick_sample(), pick_sample());
        drain();

        // Random phases, a fresh register set each; one phase runs without gaps,
        // and each phase pauses once mid-way until the output side catches up.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick_config();
            use_gaps = (ph != 3);
            hold_at  = $urandom_range(20, PHASE_ITEMS - 20);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == hold_at) drain();
                put_pair(pick_sample(), pick_sample());
            end
            drain();
        end

        // Finish with a back-to-back stream on one more register set.
        pick_config();
        use_gaps = 1'b0;
        while (items_sent < TOTAL_ITEMS)
            put_pair(pick_sample(), pick_sample());
        drain();

        $display("covered %0d pairs in, %0d pairs out, %0d register writes",
                 items_sent, result_count, reg_writes);
        $display("span from zero to full clamp, extreme gains and steps, taps past line start");
        if (fail_count == 0 && pending_pairs == 0) begin
            $display("[stereo_quadrature_flanger] OK");
        end else begin
            $display("%0d mismatches, %0d pairs missing", fail_count, pending_pairs);
            $display("[stereo_quadrature_flanger] ERROR");
        end
        $finish;
    end

endmodule
